FILE: rtl/core/coverage_interval_merge_core_macros.svh
// Assertion macros for the coverage interval merge core.
// Each macro samples on the rising edge of clock and is disabled in reset.
`ifndef COVERAGE_INTERVAL_MERGE_CORE_MACROS_SVH
`define COVERAGE_INTERVAL_MERGE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CIMC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define CIMC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CIMC_ASSERT_IMP(lbl, ante, cons, msg)
`define CIMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/cimc_pkg.sv
// ----------------------------------------------------------------------------
// cimc_pkg
// Shared constants and types of the coverage interval merge core.
// ----------------------------------------------------------------------------
package cimc_pkg;

   localparam int MaxRanges = 64;
   localparam int IdxW      = $clog2(MaxRanges);
   localparam int CntW      = $clog2(MaxRanges + 1);

   localparam logic CmdLoad = 1'b0;
   localparam logic CmdRun  = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  sheet;
      logic [31:0] start_ofs;
      logic [31:0] end_ofs;
   } item_type;

   typedef struct packed {
      logic            busy;
      logic [CntW-1:0] count;
   } back_status_type;

endpackage

FILE: rtl/core/cimc_front.sv
// ----------------------------------------------------------------------------
// cimc_front
// Takes request words, drops unused or empty ranges, queues the rest.
// ----------------------------------------------------------------------------
module cimc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [7:0]         req_sheet_index,
   input  logic [31:0]        req_start_offset,
   input  logic [31:0]        req_end_offset,
   input  logic               req_used_flag,
   output logic               q_valid,
   output cimc_pkg::item_type q_item,
   input  logic               q_pop
);

   logic [1:0]         cnt_ff, cnt_in;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   cimc_pkg::item_type slot_ff [2];
   logic               keep, push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign keep      = (req_command == cimc_pkg::CmdRun) ||
                      (req_used_flag && (req_end_offset > req_start_offset));
   assign push      = req_valid && !req_stall && keep;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{cmd: req_command, sheet: req_sheet_index,
                                start_ofs: req_start_offset, end_ofs: req_end_offset};
      end
   end

endmodule

FILE: rtl/core/cimc_back.sv
// ----------------------------------------------------------------------------
// cimc_back
// Range store, selection sort by repeated minimum scans, merge and output reg.
// ----------------------------------------------------------------------------
module cimc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  cimc_pkg::item_type        q_item,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_out_sheet,
   output logic [31:0]               rsp_out_start,
   output logic [31:0]               rsp_out_end,
   output logic                      rsp_range_valid,
   output logic                      rsp_overflowed,
   output logic                      rsp_last_range,
   output cimc_pkg::back_status_type status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SEL   = 3'd2;
   localparam logic [2:0] S_LAST  = 3'd3;
   localparam logic [2:0] S_EMPTY = 3'd4;

   localparam int CntW = cimc_pkg::CntW;
   localparam int IdxW = cimc_pkg::IdxW;
   localparam int N    = cimc_pkg::MaxRanges;

   logic [2:0]      state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            ovf_ff, ovf_in;
   logic [N-1:0]    taken_ff, taken_in;
   logic [CntW-1:0] pass_ff, pass_in;
   logic [IdxW-1:0] rd_idx_ff, rd_idx_in;
   logic            issue_ff, issue_in;
   logic            rdv_ff, rdv_in;
   logic [IdxW-1:0] tag_ff, tag_in;
   logic [39:0]     best_key_ff, best_key_in;
   logic [31:0]     best_end_ff, best_end_in;
   logic [IdxW-1:0] best_idx_ff, best_idx_in;
   logic            best_ok_ff, best_ok_in;
   logic [39:0]     cur_key_ff, cur_key_in;
   logic [31:0]     cur_end_ff, cur_end_in;
   logic            have_cur_ff, have_cur_in;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_sheet_ff, out_sheet_in;
   logic [31:0]     out_start_ff, out_start_in;
   logic [31:0]     out_end_ff, out_end_in;
   logic            out_rv_ff, out_rv_in;
   logic            out_ovf_ff, out_ovf_in;
   logic            out_last_ff, out_last_in;

   logic [71:0]     mem [N];
   logic [71:0]     rd_data_ff;
   logic            wr_en;
   logic            out_free, cand, merge;
   logic [39:0]     rd_key;
   logic [31:0]     rd_end;
   logic [CntW-1:0] last_idx, pass_nxt;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign rd_key   = rd_data_ff[71:32];
   assign rd_end   = rd_data_ff[31:0];
   assign last_idx = count_ff - CntW'(1);
   assign pass_nxt = pass_ff + CntW'(1);
   assign cand     = rdv_ff && !taken_ff[tag_ff] && (!best_ok_ff || (rd_key < best_key_ff));
   // next range overlaps or touches the open one
   assign merge    = have_cur_ff && (best_key_ff[39:32] == cur_key_ff[39:32]) &&
                     (best_key_ff[31:0] <= cur_end_ff);
   assign wr_en    = (state_ff == S_IDLE) && q_valid && (q_item.cmd == cimc_pkg::CmdLoad) &&
                     (count_ff < CntW'(N));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IdxW-1:0]] <= {q_item.sheet, q_item.start_ofs, q_item.end_ofs};
      end
      if (issue_ff) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      taken_in     = taken_ff;
      pass_in      = pass_ff;
      rd_idx_in    = rd_idx_ff;
      issue_in     = issue_ff;
      rdv_in       = (state_ff == S_SCAN) && issue_ff;
      tag_in       = rd_idx_ff;
      best_key_in  = best_key_ff;
      best_end_in  = best_end_ff;
      best_idx_in  = best_idx_ff;
      best_ok_in   = best_ok_ff;
      cur_key_in   = cur_key_ff;
      cur_end_in   = cur_end_ff;
      have_cur_in  = have_cur_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_sheet_in = out_sheet_ff;
      out_start_in = out_start_ff;
      out_end_in   = out_end_ff;
      out_rv_in    = out_rv_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.cmd == cimc_pkg::CmdLoad) begin
                  if (count_ff < CntW'(N)) begin
                     count_in = count_ff + CntW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (count_ff == '0) begin
                  state_in = S_EMPTY;
               end else begin
                  state_in    = S_SCAN;
                  issue_in    = 1'b1;
                  rd_idx_in   = '0;
                  best_ok_in  = 1'b0;
                  pass_in     = '0;
                  have_cur_in = 1'b0;
                  taken_in    = '0;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               if (CntW'(rd_idx_ff) == last_idx) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + IdxW'(1);
               end
            end
            if (cand) begin
               best_key_in = rd_key;
               best_end_in = rd_end;
               best_idx_in = tag_ff;
               best_ok_in  = 1'b1;
            end
            if (rdv_ff && (CntW'(tag_ff) == last_idx)) begin
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            if (!have_cur_ff || merge || out_free) begin
               taken_in[best_idx_ff] = 1'b1;
               pass_in               = pass_nxt;
               if (merge) begin
                  if (best_end_ff > cur_end_ff) begin
                     cur_end_in = best_end_ff;
                  end
               end else begin
                  if (have_cur_ff) begin
                     out_valid_in = 1'b1;
                     out_sheet_in = cur_key_ff[39:32];
                     out_start_in = cur_key_ff[31:0];
                     out_end_in   = cur_end_ff;
                     out_rv_in    = 1'b1;
                     out_ovf_in   = ovf_ff;
                     out_last_in  = 1'b0;
                  end
                  cur_key_in  = best_key_ff;
                  cur_end_in  = best_end_ff;
                  have_cur_in = 1'b1;
               end
               if (pass_nxt == count_ff) begin
                  state_in = S_LAST;
               end else begin
                  state_in   = S_SCAN;
                  issue_in   = 1'b1;
                  rd_idx_in  = '0;
                  best_ok_in = 1'b0;
               end
            end
         end
         S_LAST: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_sheet_in = cur_key_ff[39:32];
               out_start_in = cur_key_ff[31:0];
               out_end_in   = cur_end_ff;
               out_rv_in    = 1'b1;
               out_ovf_in   = ovf_ff;
               out_last_in  = 1'b1;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_EMPTY: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_sheet_in = '0;
               out_start_in = '0;
               out_end_in   = '0;
               out_rv_in    = 1'b0;
               out_ovf_in   = ovf_ff;
               out_last_in  = 1'b1;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         issue_ff     <= 1'b0;
         rdv_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         issue_ff     <= issue_in;
         rdv_ff       <= rdv_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      taken_ff     <= taken_in;
      pass_ff      <= pass_in;
      rd_idx_ff    <= rd_idx_in;
      tag_ff       <= tag_in;
      best_key_ff  <= best_key_in;
      best_end_ff  <= best_end_in;
      best_idx_ff  <= best_idx_in;
      best_ok_ff   <= best_ok_in;
      cur_key_ff   <= cur_key_in;
      cur_end_ff   <= cur_end_in;
      have_cur_ff  <= have_cur_in;
      out_sheet_ff <= out_sheet_in;
      out_start_ff <= out_start_in;
      out_end_ff   <= out_end_in;
      out_rv_ff    <= out_rv_in;
      out_ovf_ff   <= out_ovf_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_sheet   = out_sheet_ff;
   assign rsp_out_start   = out_start_ff;
   assign rsp_out_end     = out_end_ff;
   assign rsp_range_valid = out_rv_ff;
   assign rsp_overflowed  = out_ovf_ff;
   assign rsp_last_range  = out_last_ff;
   assign status.busy     = (state_ff != S_IDLE);
   assign status.count    = count_ff;

endmodule

FILE: rtl/core/coverage_interval_merge_core.sv
// ----------------------------------------------------------------------------
// coverage_interval_merge_core
// Collects byte ranges, then sorts, merges and emits them on a run word.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   command, sheet, start, end, used
//   rsp_     out        rsp_valid/rsp_stall   sheet, start, end, flags
//
// Load words are taken one per cycle while no run is busy, through a two-word queue.
// A run over n stored ranges makes n scans of the single-read-port range
// memory, one read per cycle, each followed by a select step. An empty run
// answers with one last word that carries no range. Reset is synchronous;
// the memory needs no clearing. rsp_stall holds the output register and any
// step that would emit a word; merges into the open range go on.
// ----------------------------------------------------------------------------
`include "coverage_interval_merge_core_macros.svh"

module coverage_interval_merge_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_sheet_index,
   input  logic [31:0] req_start_offset,
   input  logic [31:0] req_end_offset,
   input  logic        req_used_flag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_sheet,
   output logic [31:0] rsp_out_start,
   output logic [31:0] rsp_out_end,
   output logic        rsp_range_valid,
   output logic        rsp_overflowed,
   output logic        rsp_last_range
);

   logic                      q_valid;
   logic                      q_pop;
   cimc_pkg::item_type        q_item;
   cimc_pkg::back_status_type status;

   cimc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_sheet_index  (req_sheet_index),
      .req_start_offset (req_start_offset),
      .req_end_offset   (req_end_offset),
      .req_used_flag    (req_used_flag),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   cimc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_sheet   (rsp_out_sheet),
      .rsp_out_start   (rsp_out_start),
      .rsp_out_end     (rsp_out_end),
      .rsp_range_valid (rsp_range_valid),
      .rsp_overflowed  (rsp_overflowed),
      .rsp_last_range  (rsp_last_range),
      .status          (status)
   );

   `CIMC_ASSERT_IMP(a_count_bound, 1'b1, status.count <= cimc_pkg::CntW'(cimc_pkg::MaxRanges), "store count beyond depth")
   `CIMC_ASSERT_IMP(a_empty_is_last, rsp_valid && !rsp_range_valid, rsp_last_range && (rsp_out_start == 32'd0) && (rsp_out_end == 32'd0), "empty-run word malformed")
   `CIMC_ASSERT_IMP(a_range_nonempty, rsp_valid && rsp_range_valid, rsp_out_end > rsp_out_start, "merged range is empty")
   `CIMC_ASSERT_NEXT(a_run_open, status.busy && rsp_valid && rsp_stall && !rsp_last_range, status.busy, "run closed before last word")

endmodule
